// ===== rtl/chip8_subset_execute_core_unit_defines.svh =====
// Assertion macros for the CHIP-8 execute core.
`ifndef CHIP8_SUBSET_EXECUTE_CORE_UNIT_DEFINES_SVH
`define CHIP8_SUBSET_EXECUTE_CORE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define C8_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define C8_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define C8_ASSERT(label, clk, rst, prop, msg)
`define C8_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// ===== rtl/c8core_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8core_pkg
// Shared types and constants of the CHIP-8 execute core.
// ----------------------------------------------------------------------------
package c8core_pkg;
  localparam int MEM_BYTES_DEF = 4096;
  localparam int SCREEN_W_DEF  = 64;
  localparam int SCREEN_H_DEF  = 32;
  localparam logic [11:0] PC_RESET = 12'd512;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_EXEC  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_EXEC  = 2'd0;
  localparam logic [1:0] ST_UNSUP = 2'd1;
  localparam logic [1:0] ST_WROTE = 2'd2;
  localparam logic [1:0] ST_READ  = 2'd3;

  localparam logic [1:0] ADDR_PROGRAM_START = 2'd0;

  // Classified command handed from the front part to the back part.
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_EXEC  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [11:0] address;
    logic [7:0]  data_byte;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] program_counter;
    logic [11:0] index_value;
    logic [15:0] opcode;
    logic [7:0]  read_data;
    logic        collision;
  } result_t;
endpackage

// ===== rtl/c8core_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8core_in_if / c8core_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface c8core_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [11:0] address;
  logic [7:0]  data_byte;
  modport source (output valid, operation, address, data_byte, input ready);
  modport sink   (input valid, operation, address, data_byte, output ready);
endinterface

interface c8core_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [11:0] program_counter;
  logic [11:0] index_value;
  logic [15:0] opcode;
  logic [7:0]  read_data;
  logic        collision;
  modport source (output valid, status, program_counter, index_value, opcode,
                  read_data, collision, input ready);
  modport sink   (input valid, status, program_counter, index_value, opcode,
                  read_data, collision, output ready);
endinterface

// ===== rtl/chip8_subset_execute_core_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chip8_subset_execute_core_unit
// CHIP-8 execute core for a reduced instruction subset.
// ----------------------------------------------------------------------------
// One item at a time is executed. A memory write completes directly, a
// framebuffer read goes through the registered framebuffer port, and a plain
// instruction takes two byte fetches through the registered memory port, then
// decode. A screen clear then zeroes the framebuffer, one framebuffer byte a
// cycle, and a draw does one read-modify-write on the single framebuffer port
// per sprite row, or two for a row that straddles two framebuffer bytes;
// rows below the bottom edge are skipped. A waiting result holds the next
// command in the queue. After reset the block clears its 4096-byte memory and
// its framebuffer, one byte a cycle, before it takes the first item. A
// two-entry queue decouples input from execution.
module chip8_subset_execute_core_unit
  import c8core_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF,
  parameter int SCREEN_W  = SCREEN_W_DEF,
  parameter int SCREEN_H  = SCREEN_H_DEF
)(
  input  logic        clk,
  input  logic        rst,
  c8core_in_if.sink   in_ch,
  c8core_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic        cmd_valid, cmd_pop, start_we;
  cmd_t        cmd;
  logic [11:0] program_start;

  // Configuration port.
  assign pready   = 1'b1;
  assign start_we = psel && penable && pwrite && (paddr == ADDR_PROGRAM_START);
  assign prdata   = (paddr == ADDR_PROGRAM_START) ? {20'd0, program_start} : 32'd0;

  c8core_front u_front (
    .clk, .rst, .in_ch, .cmd_valid, .cmd_pop, .cmd
  );

  c8core_back #(
    .MEM_BYTES(MEM_BYTES), .SCREEN_W(SCREEN_W), .SCREEN_H(SCREEN_H)
  ) u_back (
    .clk, .rst, .cmd_valid, .cmd_pop, .cmd, .start_we,
    .start_value(pwdata[11:0]), .program_start, .out_ch
  );
endmodule

// ===== rtl/c8core_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8core_front
// Accepts input items, classifies them and queues them for the back part.
// ----------------------------------------------------------------------------
module c8core_front
  import c8core_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  c8core_in_if.sink        in_ch,
  output logic             cmd_valid,
  input  logic             cmd_pop,
  output cmd_t             cmd
);
  `include "chip8_subset_execute_core_unit_defines.svh"

  // Two-entry command queue.
  cmd_t       q [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic       push;

  // Classify the operation code.
  always_comb begin
    cmd_in.address   = in_ch.address;
    cmd_in.data_byte = in_ch.data_byte;
    case (in_ch.operation)
      OP_WRITE: cmd_in.kind = CMD_WRITE;
      OP_EXEC:  cmd_in.kind = CMD_EXEC;
      OP_READ:  cmd_in.kind = CMD_READ;
      default:  cmd_in.kind = CMD_NOP;
    endcase
  end

  assign in_ch.ready = (count != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid   = (count != 2'd0);
  assign cmd         = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

  `C8_ASSERT(a_no_pop_empty, clk, rst, cmd_pop |-> cmd_valid, "pop from empty queue")
  `C8_ASSERT(a_count_range, clk, rst, count != 2'd3, "queue count out of range")
  `C8_ASSERT(a_full_stall, clk, rst, (count == 2'd2) |-> !in_ch.ready, "full queue accepts")
endmodule

// ===== rtl/c8core_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8core_back
// Executes queued commands: memory, registers, framebuffer and result stage.
// ----------------------------------------------------------------------------
module c8core_back
  import c8core_pkg::*;
#(
  parameter int MEM_BYTES = MEM_BYTES_DEF,
  parameter int SCREEN_W  = SCREEN_W_DEF,
  parameter int SCREEN_H  = SCREEN_H_DEF
)(
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_pop,
  input  cmd_t             cmd,
  input  logic             start_we,
  input  logic [11:0]      start_value,
  output logic [11:0]      program_start,
  c8core_out_if.source     out_ch
);
  `include "chip8_subset_execute_core_unit_defines.svh"

  localparam int ROW_BYTES = SCREEN_W / 8;
  localparam int FB_BYTES  = ROW_BYTES * SCREEN_H;
  localparam int FAW       = $clog2(FB_BYTES);
  localparam int MAW       = $clog2(MEM_BYTES);
  localparam int XW        = $clog2(SCREEN_W);
  localparam int YW        = $clog2(SCREEN_H);
  localparam int CW        = $clog2(ROW_BYTES);
  localparam int CLRW      = $clog2(MEM_BYTES);

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_FETCH0 = 11'b00000000100,
    S_FETCH1 = 11'b00000001000,
    S_DECODE = 11'b00000010000,
    S_FBCLR  = 11'b00000100000,
    S_DROW   = 11'b00001000000,
    S_DRD    = 11'b00010000000,
    S_DWR    = 11'b00100000000,
    S_FBRD   = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state, state_next;

  // Main memory and framebuffer, one port each, registered read.
  logic [7:0] mem [MEM_BYTES];
  logic [7:0] fb  [FB_BYTES];
  logic [MAW-1:0] mem_addr;
  logic [7:0]     mem_wdata, mem_q;
  logic           mem_we;
  logic [FAW-1:0] fb_addr;
  logic [7:0]     fb_wdata, fb_q;
  logic           fb_we;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    mem_q <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (fb_we) fb[fb_addr] <= fb_wdata;
    fb_q <= fb[fb_addr];
  end

  // Architectural registers.
  logic [7:0]  vreg [16];
  logic [11:0] pc, index_reg;
  logic [7:0]  hi_byte;
  logic [15:0] opc;
  logic [CLRW:0] clr_cnt;
  logic        is_fbread;
  // Draw walker. The row position carries one extra bit so that the
  // bottom edge is seen instead of wrapping to the top.
  logic [3:0]  row, rows;
  logic [XW-1:0] x0;
  logic [YW:0]   py;
  logic [15:0] shifted;
  logic [CW-1:0] col;
  logic        second, hit;
  result_t     res;
  logic        out_full;

  logic [CW-1:0] col0;
  logic [2:0]    sub;
  logic [FAW-1:0] fb_row_addr;

  assign col0     = x0[XW-1:3];
  assign sub      = x0[2:0];
  assign fb_row_addr = FAW'({py[YW-1:0], {CW{1'b0}}}) | FAW'(col);

  assign out_ch.valid           = out_full;
  assign out_ch.status          = res.status;
  assign out_ch.program_counter = res.program_counter;
  assign out_ch.index_value     = res.index_value;
  assign out_ch.opcode          = res.opcode;
  assign out_ch.read_data       = res.read_data;
  assign out_ch.collision       = res.collision;

  // Next state and memory port control.
  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = pc[MAW-1:0];
    mem_wdata  = cmd.data_byte;
    fb_we      = 1'b0;
    fb_addr    = fb_row_addr;
    fb_wdata   = fb_q ^ (second ? shifted[7:0] : shifted[15:8]);
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt[MAW-1:0];
        mem_wdata = 8'd0;
        fb_we     = (clr_cnt < (CLRW+1)'(FB_BYTES));
        fb_addr   = clr_cnt[FAW-1:0];
        fb_wdata  = 8'd0;
        if (clr_cnt == (CLRW+1)'(MEM_BYTES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid && !out_full) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_WRITE: begin
              mem_we     = 1'b1;
              mem_addr   = cmd.address[MAW-1:0];
              state_next = S_DONE;
            end
            CMD_EXEC: begin
              mem_addr   = pc[MAW-1:0];
              state_next = S_FETCH0;
            end
            CMD_READ: begin
              fb_addr    = cmd.address[FAW-1:0];
              state_next = S_FBRD;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_FETCH0: begin
        mem_addr   = MAW'(pc + 12'd1);
        state_next = S_FETCH1;
      end
      S_FETCH1: begin
        // Hold the low byte address so it is still on the read port at decode.
        mem_addr   = MAW'(pc + 12'd1);
        state_next = S_DECODE;
      end
      S_DECODE: begin
        mem_addr = index_reg[MAW-1:0];
        if ({hi_byte, mem_q} == 16'h00E0) state_next = S_FBCLR;
        else if (hi_byte[7:4] == 4'hD) state_next = S_DROW;
        else state_next = S_DONE;
      end
      S_FBCLR: begin
        fb_we    = 1'b1;
        fb_addr  = clr_cnt[FAW-1:0];
        fb_wdata = 8'd0;
        if (clr_cnt == (CLRW+1)'(FB_BYTES - 1)) state_next = S_DONE;
      end
      S_DROW: begin
        // Start of one sprite row; sprite byte read was issued last cycle.
        mem_addr = MAW'(index_reg + {8'd0, row});
        if (row == rows || py >= (YW+1)'(SCREEN_H)) state_next = S_DONE;
        else state_next = S_DRD;
      end
      S_DRD: state_next = S_DWR;
      S_DWR: begin
        fb_we = 1'b1;
        if (!second && sub != 3'd0 && col != CW'(ROW_BYTES - 1)) state_next = S_DRD;
        else state_next = S_DROW;
        mem_addr = MAW'(index_reg + {8'd0, row} + 12'd1);
      end
      S_FBRD: state_next = S_DONE;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_cnt       <= '0;
      out_full      <= 1'b0;
      pc            <= PC_RESET;
      program_start <= PC_RESET;
      index_reg     <= 12'd0;
      for (int i = 0; i < 16; i++) vreg[i] <= 8'd0;
    end else begin
      state <= state_next;
      if (out_ch.valid && out_ch.ready) out_full <= 1'b0;
      if (start_we) begin
        program_start <= start_value;
        pc            <= start_value;
      end
      case (state)
        S_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        S_IDLE: begin
          clr_cnt <= '0;
          // A command is only taken once any waiting result has been accepted.
          if (cmd_pop) begin
            is_fbread     <= 1'b0;
            res.opcode    <= 16'd0;
            res.read_data <= 8'd0;
            res.collision <= 1'b0;
            case (cmd.kind)
              CMD_WRITE: res.status <= ST_WROTE;
              CMD_READ: begin
                res.status <= ST_READ;
                is_fbread  <= (cmd.address < 12'(FB_BYTES));
              end
              CMD_EXEC: res.status <= ST_EXEC;
              default:  res.status <= ST_UNSUP;
            endcase
          end
        end
        S_FETCH0: begin
          hi_byte <= mem_q;
        end
        S_FETCH1: begin
          pc <= pc + 12'd2;
        end
        S_DECODE: begin
          opc        <= {hi_byte, mem_q};
          res.opcode <= {hi_byte, mem_q};
          row   <= 4'd0;
          rows  <= mem_q[3:0];
          hit   <= 1'b0;
        end
        S_FBCLR: clr_cnt <= clr_cnt + 1'b1;
        S_DROW: begin
          col     <= col0;
          second  <= 1'b0;
          shifted <= {mem_q, 8'd0} >> sub;
        end
        S_DWR: begin
          hit <= hit | (|(fb_q & (second ? shifted[7:0] : shifted[15:8])));
          if (!second && sub != 3'd0 && col != CW'(ROW_BYTES - 1)) begin
            second <= 1'b1;
            col    <= col + 1'b1;
          end else begin
            row <= row + 4'd1;
            py  <= py + 1'b1;
          end
        end
        S_FBRD: begin
          if (is_fbread) res.read_data <= fb_q;
        end
        default: ;
      endcase
      if (state == S_DECODE) begin
        x0 <= XW'(vreg[hi_byte[3:0]]);
        py <= {1'b0, vreg[mem_q[7:4]][YW-1:0]};
        case (hi_byte[7:4])
          4'h0: if ({hi_byte, mem_q} != 16'h00E0) res.status <= ST_UNSUP;
          4'h1: pc <= {hi_byte[3:0], mem_q};
          4'h6: vreg[hi_byte[3:0]] <= mem_q;
          4'h7: vreg[hi_byte[3:0]] <= vreg[hi_byte[3:0]] + mem_q;
          4'hA: index_reg <= {hi_byte[3:0], mem_q};
          4'hB: pc <= {hi_byte[3:0], mem_q} + {4'd0, vreg[hi_byte[3:0]]};
          4'hD: ;
          default: res.status <= ST_UNSUP;
        endcase
      end
      if (state == S_DROW && state_next == S_DONE && opc[15:12] == 4'hD) begin
        vreg[15]      <= {7'd0, hit};
        res.collision <= hit;
      end
      if (state == S_DONE) begin
        res.program_counter <= pc;
        res.index_value     <= index_reg;
        out_full            <= 1'b1;
      end
    end
  end

  `C8_ASSERT(a_no_overwrite, clk, rst, (state == S_DONE) |-> !out_full, "result overwritten")
  `C8_ASSERT(a_pop_idle, clk, rst, cmd_pop |-> (state == S_IDLE), "pop outside idle")
  `C8_ASSERT(a_draw_rows, clk, rst, (state == S_DRD) |-> (row < rows), "row beyond sprite")
endmodule
